// ===== design/srd_pkg.sv =====
// Shared constants, types and helpers for the status reply deframer.
package srd_pkg;

  localparam int REPLY_LEN = 11;
  localparam int WIN_AW    = $clog2(REPLY_LEN);

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] LEN_OK      = 8'h07;
  localparam logic [7:0] FLAG_MOVING = 8'h01;
  localparam logic [7:0] FLAG_OVERC  = 8'h02;
  localparam logic [7:0] FLAG_HOLD   = 8'h04;

  // request kinds on the input stream
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // result kinds on the output stream
  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_BAD_LEN = 2'd1;
  localparam logic [1:0] RES_TIMEOUT = 2'd2;

  // byte positions inside an aligned frame
  localparam logic [WIN_AW-1:0] POS_ID      = WIN_AW'(2);
  localparam logic [WIN_AW-1:0] POS_LEN     = WIN_AW'(3);
  localparam logic [WIN_AW-1:0] POS_INSTR   = WIN_AW'(4);
  localparam logic [WIN_AW-1:0] POS_ANG_LO  = WIN_AW'(5);
  localparam logic [WIN_AW-1:0] POS_ANG_HI  = WIN_AW'(6);
  localparam logic [WIN_AW-1:0] POS_CUR_LO  = WIN_AW'(7);
  localparam logic [WIN_AW-1:0] POS_CUR_HI  = WIN_AW'(8);
  localparam logic [WIN_AW-1:0] POS_FLAGS   = WIN_AW'(9);
  localparam logic [WIN_AW-1:0] POS_CHK     = WIN_AW'(REPLY_LEN - 1);

  localparam int OUT_DW = 56;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [WIN_AW-1:0] idx;
    logic              last_ff;
    logic              chk_ok;
    logic              len_ok;
    logic [7:0]        dev_id;
    logic [7:0]        instr_code;
    logic signed [15:0] angle;
    logic [15:0]       drive_cur;
    logic [7:0]        flags;
  } scan_res_t;

  // add two window offsets modulo the window length
  function automatic logic [WIN_AW-1:0] wrap_add(input logic [WIN_AW-1:0] a,
                                                 input logic [WIN_AW-1:0] b);
    logic [WIN_AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (WIN_AW+1)'(REPLY_LEN)) begin
      s = s - (WIN_AW+1)'(REPLY_LEN);
    end
    return s[WIN_AW-1:0];
  endfunction

endpackage

// ===== design/srd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module srd_ram #(
  parameter int DEPTH = 11,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/srd_scan.sv =====
// Window scanner: consumes the window one byte per cycle from the RAM read port.
module srd_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clr,
  input  logic                      issue,
  input  logic [srd_pkg::WIN_AW-1:0] pos,
  input  logic [7:0]                rdata,
  output srd_pkg::scan_res_t        res
);
  import srd_pkg::*;

  logic              vld;
  logic [WIN_AW-1:0] pos_q;
  logic              prev_ff;
  logic [7:0]        sum;
  logic              cur_ff;

  assign cur_ff = (rdata == HDR_BYTE);

  // control state and payload captured as bytes stream past
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld       <= 1'b0;
      prev_ff   <= 1'b0;
      sum       <= '0;
      res.done  <= 1'b0;
      res.found <= 1'b0;
    end else begin
      vld   <= issue;
      pos_q <= pos;
      if (vld) begin
        prev_ff <= cur_ff;
        if (!res.found && prev_ff && cur_ff && pos_q != '0) begin
          res.found <= 1'b1;
          res.idx   <= pos_q - WIN_AW'(1);
        end
        if (pos_q >= POS_ID && pos_q <= POS_FLAGS) begin
          sum <= sum + rdata;
        end
        case (pos_q)
          POS_ID:     res.dev_id          <= rdata;
          POS_LEN:    res.len_ok          <= (rdata == LEN_OK);
          POS_INSTR:  res.instr_code      <= rdata;
          POS_ANG_LO: res.angle[7:0]      <= rdata;
          POS_ANG_HI: res.angle[15:8]     <= rdata;
          POS_CUR_LO: res.drive_cur[7:0]  <= rdata;
          POS_CUR_HI: res.drive_cur[15:8] <= rdata;
          POS_FLAGS:  res.flags           <= rdata;
          POS_CHK: begin
            res.chk_ok  <= (rdata == ~sum);
            res.last_ff <= cur_ff;
            res.done    <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/status_reply_deframer.sv =====
// Status reply deframer top level: request control, window RAM and result register.
// Scan: a byte that fills the window starts 11 RAM reads, one per cycle; a good frame
//   then offers its result through ST_EMIT, as does a reply timeout.
// Flow: one request at a time; s_tready stays low while a window is scanned or a result
//   waits in ST_EMIT, and a new result holds the input while the last one is untaken.
// Reset: control, phase, counters and output valid clear; timeout_ticks returns to 20.
module status_reply_deframer (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] echo_len
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [srd_pkg::OUT_DW-1:0] m_tdata,
  // [7:0] dev_id, [15:8] instr_code, [31:16] angle, [47:32] drive_cur,
  // [48] in_motion, [49] overcurrent, [50] torque_hold, [55:51] zero
  output logic [1:0]  m_tuser,   // [1:0] result_code
  // timeout register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // timeout_ticks
);
  import srd_pkg::*;

  typedef enum logic [1:0] {ST_READY, ST_SCAN, ST_EMIT} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_ECHO, PH_REPLY} phase_t;

  state_t            st;
  phase_t            phase;
  logic [WIN_AW-1:0] head;       // window start inside the circular RAM
  logic [WIN_AW-1:0] fill;       // bytes held in the window
  logic [WIN_AW-1:0] rd_k;       // next window offset to read during a scan
  logic [7:0]        echo_left;
  logic [7:0]        ticks_left;
  logic [7:0]        timeout_ticks;
  logic [1:0]        pend_code;
  logic [OUT_DW-1:0] pend_data;

  logic              accept;
  logic [1:0]        req_type;
  logic [7:0]        rx_byte;
  logic [7:0]        echo_len;
  logic              wr_en;
  logic [WIN_AW-1:0] wr_addr;
  logic              rd_en;
  logic [WIN_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              scan_clr;
  logic              out_free;
  logic [WIN_AW-1:0] drop;
  logic              frame_good;
  logic [OUT_DW-1:0] good_data;
  scan_res_t         scan;

  assign req_type  = s_tuser;
  assign rx_byte   = s_tdata[7:0];
  assign echo_len  = s_tdata[15:8];
  assign s_tready  = (st == ST_READY);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // append reply bytes at the tail of the circular window
  assign wr_en    = accept && (req_type == REQ_BYTE) && (phase == PH_REPLY);
  assign wr_addr  = wrap_add(head, fill);
  // a byte that fills the window starts a fresh scan
  assign scan_clr = wr_en && (fill == WIN_AW'(REPLY_LEN - 1));

  // read the window front to back during a scan
  assign rd_en   = (st == ST_SCAN) && (rd_k != WIN_AW'(REPLY_LEN));
  assign rd_addr = wrap_add(head, rd_k);

  srd_ram #(
    .DEPTH (REPLY_LEN),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (rx_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  srd_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .clr   (scan_clr),
    .issue (rd_en),
    .pos   (rd_k),
    .rdata (rd_data),
    .res   (scan)
  );

  // Drop two bytes after a bad checksum, up to the header when it sits further in,
  // and all but the last byte when no header shows up.
  always_comb begin
    if (scan.found) begin
      drop = (scan.idx == '0) ? WIN_AW'(2) : scan.idx;
    end else begin
      drop = WIN_AW'(REPLY_LEN - 1);
    end
  end

  assign frame_good = scan.found && (scan.idx == '0) && scan.chk_ok;

  always_comb begin
    good_data          = '0;
    good_data[7:0]     = scan.dev_id;
    good_data[15:8]    = scan.instr_code;
    good_data[31:16]   = scan.angle;
    good_data[47:32]   = scan.drive_cur;
    good_data[48]      = |(scan.flags & FLAG_MOVING);
    good_data[49]      = |(scan.flags & FLAG_OVERC);
    good_data[50]      = |(scan.flags & FLAG_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_READY;
      phase         <= PH_IDLE;
      head          <= '0;
      fill          <= '0;
      rd_k          <= '0;
      echo_left     <= '0;
      ticks_left    <= '0;
      timeout_ticks <= 8'd20;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_data;
      end
      // release a taken result unless a new one loads in its place
      if (m_tvalid && m_tready && st != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        ST_READY: begin
          if (accept) begin
            case (req_type)
              REQ_START: begin
                echo_left <= echo_len;
                fill      <= '0;
                ticks_left <= timeout_ticks;
                phase     <= (echo_len == '0) ? PH_REPLY : PH_ECHO;
              end
              REQ_BYTE: begin
                if (phase == PH_ECHO) begin
                  echo_left <= echo_left - 8'd1;
                  if (echo_left == 8'd1) begin
                    phase      <= PH_REPLY;
                    ticks_left <= timeout_ticks;
                    fill       <= '0;
                  end
                end else if (phase == PH_REPLY) begin
                  fill <= fill + WIN_AW'(1);
                  if (scan_clr) begin
                    rd_k <= '0;
                    st   <= ST_SCAN;
                  end
                end
              end
              REQ_TICK: begin
                if (phase != PH_IDLE) begin
                  if (ticks_left > 8'd1) begin
                    ticks_left <= ticks_left - 8'd1;
                  end else if (phase == PH_ECHO) begin
                    // echo drain expired: open the reply wait anyway
                    echo_left  <= '0;
                    phase      <= PH_REPLY;
                    ticks_left <= timeout_ticks;
                    fill       <= '0;
                  end else begin
                    ticks_left <= '0;
                    phase      <= PH_IDLE;
                    fill       <= '0;
                    pend_code  <= RES_TIMEOUT;
                    pend_data  <= '0;
                    st         <= ST_EMIT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_k <= rd_k + WIN_AW'(1);
          end
          if (scan.done) begin
            if (frame_good) begin
              phase     <= PH_IDLE;
              fill      <= '0;
              pend_code <= scan.len_ok ? RES_OK : RES_BAD_LEN;
              pend_data <= scan.len_ok ? good_data : '0;
              st        <= ST_EMIT;
            end else begin
              // advance the window start; a lone trailing header byte stays put
              head <= wrap_add(head, drop);
              if (scan.found) begin
                fill <= WIN_AW'(REPLY_LEN) - drop;
              end else begin
                fill <= scan.last_ff ? WIN_AW'(1) : '0;
              end
              st <= ST_READY;
            end
          end
        end
        ST_EMIT: begin
          // hold the result until the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            st       <= ST_READY;
          end
        end
        default: st <= ST_READY;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (st == ST_EMIT && out_free) begin
      m_tdata <= pend_data;
      m_tuser <= pend_code;
    end
  end

endmodule

// ===== tb/srd_reply_checker.sv =====
// Reply checker for the status reply deframer: predicts results and compares them.
module srd_reply_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [15:0]                s_tdata,   // [7:0] rx_byte, [15:8] echo_len
  input  logic [1:0]                 s_tuser,   // [1:0] req_type
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [srd_pkg::OUT_DW-1:0] m_tdata,   // [7:0] id, [15:8] instr, [31:16] angle,
                                                // [47:32] current, [50:48] flags
  input  logic [1:0]                 m_tuser,   // [1:0] result_code
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [7:0]                 cfg_data,
  output int                         fail_count,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import srd_pkg::*;

  typedef enum logic [1:0] {WAIT_IDLE, WAIT_ECHO, WAIT_REPLY} wait_stage_t;

  typedef struct packed {
    logic [1:0]         code;
    logic [7:0]         dev_id;
    logic [7:0]         instr_code;
    logic signed [15:0] angle;
    logic [15:0]        drive_cur;
    logic               in_motion;
    logic               overcurrent;
    logic               torque_hold;
  } status_t;

  logic [7:0]  reply_win [REPLY_LEN];
  int          win_fill;
  wait_stage_t stage;
  logic [7:0]  echo_left;
  logic [7:0]  ticks_left;
  logic [7:0]  tick_limit;
  status_t     replies_due [$];
  int          errors;

  function automatic void enter_reply();
    stage      = WAIT_REPLY;
    ticks_left = tick_limit;
    win_fill   = 0;
  endfunction

  function automatic void drop_lead(input int n);
    if (n >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int k = 0; k + n < win_fill; k++) reply_win[k] = reply_win[k + n];
      win_fill -= n;
    end
  endfunction

  // Align the full window to a header and try to take a frame from it.
  function automatic bit scan_window(output status_t r);
    int         idx;
    bit         found;
    logic [7:0] sum;
    logic [7:0] fl;
    r = '0;
    while (win_fill >= REPLY_LEN) begin
      idx   = 0;
      found = 1'b0;
      while (!found && idx + 1 < win_fill) begin
        if (reply_win[idx] == HDR_BYTE && reply_win[idx + 1] == HDR_BYTE) found = 1'b1;
        else idx++;
      end
      if (!found) begin
        // keep a trailing 0xFF as a possible header start
        if (reply_win[win_fill - 1] == HDR_BYTE) begin
          reply_win[0] = HDR_BYTE;
          win_fill     = 1;
        end else begin
          win_fill = 0;
        end
        return 1'b0;
      end
      drop_lead(idx);
      if (win_fill < REPLY_LEN) return 1'b0;
      sum = 8'h00;
      for (int k = 2; k + 1 < REPLY_LEN; k++) sum += reply_win[k];
      if (reply_win[POS_CHK] == ~sum) begin
        if (reply_win[POS_LEN] != LEN_OK) begin
          r.code = RES_BAD_LEN;
        end else begin
          fl            = reply_win[POS_FLAGS];
          r.code        = RES_OK;
          r.dev_id      = reply_win[POS_ID];
          r.instr_code  = reply_win[POS_INSTR];
          r.angle       = {reply_win[POS_ANG_HI], reply_win[POS_ANG_LO]};
          r.drive_cur   = {reply_win[POS_CUR_HI], reply_win[POS_CUR_LO]};
          r.in_motion   = |(fl & FLAG_MOVING);
          r.overcurrent = |(fl & FLAG_OVERC);
          r.torque_hold = |(fl & FLAG_HOLD);
        end
        stage    = WAIT_IDLE;
        win_fill = 0;
        return 1'b1;
      end
      // bad checksum: drop the header and rescan
      drop_lead(2);
    end
    return 1'b0;
  endfunction

  function automatic bit absorb_request(input logic [1:0] kind, input logic [7:0] rx,
                                        input logic [7:0] elen, output status_t r);
    r = '0;
    case (kind)
      REQ_START: begin
        echo_left = elen;
        win_fill  = 0;
        if (elen == 8'd0) begin
          enter_reply();
        end else begin
          stage      = WAIT_ECHO;
          ticks_left = tick_limit;
        end
      end
      REQ_BYTE: begin
        if (stage == WAIT_ECHO) begin
          echo_left = echo_left - 8'd1;
          if (echo_left == 8'd0) enter_reply();
        end else if (stage == WAIT_REPLY) begin
          if (win_fill < REPLY_LEN) begin
            reply_win[win_fill] = rx;
            win_fill++;
          end
          return scan_window(r);
        end
      end
      REQ_TICK: begin
        if (stage != WAIT_IDLE) begin
          if (ticks_left > 8'd1) begin
            ticks_left = ticks_left - 8'd1;
          end else begin
            ticks_left = 8'd0;
            if (stage == WAIT_ECHO) begin
              echo_left = 8'd0;
              enter_reply();
            end else begin
              stage    = WAIT_IDLE;
              win_fill = 0;
              r.code   = RES_TIMEOUT;
              return 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    status_t due;
    status_t fresh;
    if (rst) begin
      stage      = WAIT_IDLE;
      win_fill   = 0;
      echo_left  = 8'd0;
      ticks_left = 8'd0;
      tick_limit = 8'd20;
      replies_due.delete();
    end else begin
      // retire before predicting: a result never belongs to a request taken at the same edge
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          $error("result with none awaited: result_code %0d", m_tuser);
          errors++;
        end else begin
          due = replies_due.pop_front();
          check_field("result_code", due.code, m_tuser);
          check_field("dev_id", due.dev_id, m_tdata[7:0]);
          check_field("instr_code", due.instr_code, m_tdata[15:8]);
          check_field("angle", due.angle, $signed(m_tdata[31:16]));
          check_field("drive_cur", due.drive_cur, m_tdata[47:32]);
          check_field("in_motion", due.in_motion, m_tdata[48]);
          check_field("overcurrent", due.overcurrent, m_tdata[49]);
          check_field("torque_hold", due.torque_hold, m_tdata[50]);
          check_field("pad", 64'sd0, m_tdata[55:51]);
        end
      end
      if (cfg_valid && cfg_ready) tick_limit = cfg_data;
      if (s_tvalid && s_tready) begin
        if (absorb_request(s_tuser, s_tdata[7:0], s_tdata[15:8], fresh))
          replies_due.push_back(fresh);
      end
    end
    fail_count  <= errors;
    outstanding <= replies_due.size();
  end

endmodule

// ===== tb/tb_status_reply_deframer.sv =====
// Testbench top for the status reply deframer: stimulus, handshake pacing and verdict.
module tb_status_reply_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import srd_pkg::*;

  // request kind the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // receiver hold-off that backs the block up
  localparam int LONG_HOLD = 300;
  // cycles a window scan may still run after the last result
  localparam int SCAN_SETTLE = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;       // [7:0] rx_byte, [15:8] echo_len
  logic [1:0]        s_tuser = REQ_BYTE; // [1:0] req_type
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data = 8'd0;

  int         fail_count;
  int         outstanding;
  bit         calm = 1'b0;  // both sides run without gaps while set
  int         hold_asks = 0;
  int         holds_seen = 0;
  int         rx_hold = 0;
  logic [7:0] frame_buf [REPLY_LEN];

  always #2 clk = ~clk;

  status_reply_deframer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  srd_reply_checker status_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Mostly no gap, some short ones, a few long ones; none at all while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: take a long hold-off when asked, otherwise stall at random.
  always @(posedge clk) begin
    if (hold_asks != holds_seen) begin
      holds_seen = hold_asks;
      rx_hold    = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      rx_hold = pick_gap();
      m_tready <= (rx_hold == 0);
    end
  end

  // Offer one request after a random gap and hold it until it is taken.
  // Valid stays high on return so back-to-back requests need no extra edge.
  task automatic push_req(input logic [1:0] kind, input logic [7:0] rx, input logic [7:0] elen);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {elen, rx};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, wait for every awaited result, then let any scan finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] ticks);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Build a reply frame; corrupt flips checksum bits so the frame is rejected.
  task automatic fill_frame(input logic [7:0] id, input logic [7:0] len, input logic [7:0] instr,
                            input logic [15:0] ang, input logic [15:0] cur,
                            input logic [7:0] flags, input bit corrupt);
    logic [7:0] sum;
    frame_buf[0]          = HDR_BYTE;
    frame_buf[1]          = HDR_BYTE;
    frame_buf[POS_ID]     = id;
    frame_buf[POS_LEN]    = len;
    frame_buf[POS_INSTR]  = instr;
    frame_buf[POS_ANG_LO] = ang[7:0];
    frame_buf[POS_ANG_HI] = ang[15:8];
    frame_buf[POS_CUR_LO] = cur[7:0];
    frame_buf[POS_CUR_HI] = cur[15:8];
    frame_buf[POS_FLAGS]  = flags;
    sum = 8'h00;
    for (int k = 2; k + 1 < REPLY_LEN; k++) sum += frame_buf[k];
    frame_buf[POS_CHK] = ~sum ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'h00);
  endtask

  // Send the first count frame bytes, slipping in a tick now and then.
  task automatic send_frame(input int count, input int tick_pct);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < tick_pct) push_req(REQ_TICK, 8'($urandom), 8'($urandom));
      push_req(REQ_BYTE, frame_buf[k], 8'($urandom));
    end
  endtask

  // One reply wait: start, echo, optional line noise, then a frame that may be
  // broken (bad length, bad checksum, cut short). n returns the requests sent, ticks aside.
  task automatic reply_attempt(output int n);
    int         r;
    int         elen;
    int         noise;
    int         cut;
    logic [7:0] b;
    calm <= ($urandom_range(0, 7) == 0);
    r = $urandom_range(0, 99);
    if (r < 40) elen = 0;
    else if (r < 85) elen = $urandom_range(1, 4);
    else elen = $urandom_range(0, 255);
    push_req(REQ_START, 8'($urandom), 8'(elen));
    n = 1;
    // long echoes are left for ticks to expire
    if (elen <= 4) begin
      repeat (elen) begin
        push_req(REQ_BYTE, 8'($urandom), 8'($urandom));
        n++;
      end
    end
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (noise) begin
      b = ($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom);
      push_req(REQ_BYTE, b, 8'($urandom));
      n++;
    end
    fill_frame(($urandom_range(0, 9) == 0) ? HDR_BYTE : 8'($urandom),
               ($urandom_range(0, 6) == 0) ? 8'($urandom) : LEN_OK,
               8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
               $urandom_range(0, 6) == 0);
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(3, REPLY_LEN - 1) : REPLY_LEN;
    send_frame(cut, 3);
    n += cut;
  endtask

  // Mostly well-formed reply waits; the rest is requests of any kind with random data.
  task automatic random_phase(input int quota);
    int done_items;
    int n;
    done_items = 0;
    while (done_items < quota) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) push_req(2'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        reply_attempt(n);
        done_items += n;
      end
    end
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: one tick per phase makes expiry quick to reach.
    write_timeout(8'd1);
    // idle requests and the unused request kind are dropped
    push_req(REQ_BYTE, 8'hFF, 8'h00);
    push_req(REQ_TICK, 8'h00, 8'hFF);
    push_req(REQ_UNUSED, 8'hFF, 8'hFF);
    // longest echo: first tick expires the echo, second times out the reply
    push_req(REQ_START, 8'h00, 8'hFF);
    push_req(REQ_TICK, 8'hFF, 8'h00);
    push_req(REQ_TICK, 8'h00, 8'h00);
    // short echo drained by bytes, then a frame at the field extremes
    push_req(REQ_START, 8'hFF, 8'd2);
    push_req(REQ_BYTE, 8'h00, 8'h00);
    push_req(REQ_BYTE, 8'hFF, 8'hFF);
    fill_frame(8'hFF, LEN_OK, 8'h00, 16'h8000, 16'hFFFF, 8'h07, 1'b0);
    send_frame(REPLY_LEN, 0);
    // zero echo goes straight to the reply wait; one tick times it out
    push_req(REQ_START, 8'h00, 8'h00);
    push_req(REQ_TICK, 8'h00, 8'h00);
    settle();

    // Backpressure: hold the receiver while frames keep coming in.
    write_timeout(8'd255);
    hold_asks <= hold_asks + 1;
    repeat (3) begin
      push_req(REQ_START, 8'($urandom), 8'h00);
      fill_frame(8'($urandom), LEN_OK, 8'($urandom), 16'($urandom), 16'($urandom),
                 8'($urandom), 1'b0);
      send_frame(REPLY_LEN, 0);
    end
    settle();

    // Full-length reply timeout at the largest setting.
    calm <= 1'b1;
    push_req(REQ_START, 8'h00, 8'h00);
    repeat (255) push_req(REQ_TICK, 8'($urandom), 8'($urandom));
    settle();
    calm <= 1'b0;

    // Zero timeout: any tick in a wait expires it.
    write_timeout(8'd0);
    random_phase(100);
    settle();

    repeat (3) begin
      write_timeout(8'($urandom_range(2, 12)));
      random_phase(120);
      settle();
    end

    // Drain: wait for stragglers, bounded, then let the block go quiet.
    s_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < 5000);
    repeat (40) @(posedge clk);
    if (outstanding != 0) $error("%0d results never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/srd_pkg.sv
design/srd_ram.sv
design/srd_scan.sv
design/status_reply_deframer.sv
tb/srd_reply_checker.sv
tb/tb_status_reply_deframer.sv
